@@ src/isq_pkg.sv @@
// Shared types, codes and constants for the indexed sequence store.
`default_nettype none

package isq_pkg;

    localparam int DATA_W       = 32;
    localparam int MODE_W       = 3;
    localparam int POS_W        = 5;
    localparam int CAPACITY_DEF = 32;

    // Operation codes as they arrive on the mode field
    localparam logic [MODE_W-1:0] MODE_GET      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP     = 3'd4;

    // Classified operation kinds handed from front to back
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_GET      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INS_TAIL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BAD      = 3'd5;

    // Data returned by a get that misses
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } op_t;

endpackage

`default_nettype wire

@@ src/isq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/isq_front.sv @@
// Front end: accepts input beats, classifies the mode and queues the operation.
`default_nettype none

module isq_front
    import isq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic signed [DATA_W-1:0] item_value,
    output logic                          q_valid,
    output op_t                           q_op,
    input  wire logic                     q_pop
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    op_t        op_in;

    // Classify the incoming mode
    always_comb
    begin
        op_in.position = position;
        op_in.value    = item_value;
        unique case (mode)
            MODE_GET:      op_in.kind = KIND_GET;
            MODE_INS_HEAD: op_in.kind = KIND_INS_HEAD;
            MODE_INS_TAIL: op_in.kind = KIND_INS_TAIL;
            MODE_REMOVE:   op_in.kind = KIND_REMOVE;
            MODE_DUMP:     op_in.kind = KIND_DUMP;
            default:       op_in.kind = KIND_BAD;
        endcase
    end

    // Stall only on a full queue
    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_op     = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold the queued operations
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

`default_nettype wire

@@ src/isq_back.sv @@
// Back end: executes queued operations on a circular list in RAM, drives results.
`default_nettype none

module isq_back
    import isq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire op_t                q_op,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [DATA_W-1:0] data,
    output logic                    ok,
    output logic                    last
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    localparam logic [AW:0]   CAP_WRAP = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_ADR = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GET  = 2'd1;
    localparam logic [1:0] ST_RM   = 2'd2;
    localparam logic [1:0] ST_DUMP = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic                     out_ok_reg, out_ok_next;
    logic                     out_last_reg, out_last_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    logic                     out_free;
    logic                     full;
    logic [CMP_W-1:0]         pos_c;
    logic [CMP_W-1:0]         cnt_c;
    logic [AW-1:0]            pos_a;
    logic [AW-1:0]            head_dec;
    logic [CW-1:0]            idx_c;

    // Map a list position to a RAM address past the head, with wrap
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= CAP_WRAP)
        begin
            sum = sum - CAP_WRAP;
        end
        return sum[AW-1:0];
    endfunction

    isq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign full     = (count_reg == CAP_CNT);
    assign pos_c    = CMP_W'(q_op.position);
    assign cnt_c    = CMP_W'(count_reg);
    assign pos_a    = pos_c[AW-1:0];
    assign head_dec = (head_reg == '0) ? LAST_ADR : head_reg - AW'(1);
    assign idx_c    = CW'(idx_reg);

    // Sequence the operations
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = phys(head_reg, idx_reg);
        ram_wdata      = q_op.value;
        ram_re         = 1'b0;
        ram_raddr      = phys(head_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_ok_next    = 1'b0;
                    out_last_next  = 1'b1;
                    case (q_op.kind)
                        KIND_GET:
                        begin
                            if (pos_c < cnt_c)
                            begin
                                // Result waits for the RAM read
                                out_valid_next = 1'b0;
                                ram_re         = 1'b1;
                                ram_raddr      = phys(head_reg, pos_a);
                                state_next     = ST_GET;
                            end
                            else
                            begin
                                out_data_next = MISS_VALUE;
                            end
                        end
                        KIND_INS_HEAD:
                        begin
                            if (!full)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = head_dec;
                                head_next   = head_dec;
                                count_next  = count_reg + CW'(1);
                                out_ok_next = 1'b1;
                            end
                        end
                        KIND_INS_TAIL:
                        begin
                            if (!full)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = phys(head_reg, count_reg[AW-1:0]);
                                count_next  = count_reg + CW'(1);
                                out_ok_next = 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (pos_c < cnt_c)
                            begin
                                count_next  = count_reg - CW'(1);
                                out_ok_next = 1'b1;
                                // Close the gap when entries follow the removed one
                                if (pos_c + CMP_W'(1) < cnt_c)
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = phys(head_reg, pos_a + AW'(1));
                                    idx_next   = pos_a;
                                    state_next = ST_RM;
                                end
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (count_reg != '0)
                            begin
                                out_valid_next = 1'b0;
                                ram_re         = 1'b1;
                                ram_raddr      = head_reg;
                                idx_next       = '0;
                                state_next     = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            out_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_GET:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ram_rdata;
                    out_ok_next    = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_RM:
            begin
                // Move the fetched entry down one place, fetch the next if one follows
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                if (idx_c + CW'(1) < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = phys(head_reg, idx_reg + AW'(2));
                    idx_next  = idx_reg + AW'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = ram_rdata;
                    out_ok_next    = 1'b1;
                    out_last_next  = (idx_c + CW'(1) == count_reg);
                    if (idx_c + CW'(1) == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = phys(head_reg, idx_reg + AW'(1));
                        idx_next  = idx_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign ok        = out_ok_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

@@ src/indexed_sequence_store_core.sv @@
// Top level of the indexed sequence store: front queue plus RAM-backed list engine.
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries held in a circular RAM
// with a head pointer. Each input beat carries one operation (get, insert at
// head, insert at tail, remove, dump) and yields one result beat, except a
// dump of a non-empty list, which yields one beat per entry with last set on
// the final one. A two-entry queue behind the input lets new beats land while
// the list engine works or the result side stalls. Inserts, misses and failed
// removes are answered from the idle state; a get that hits waits for the
// registered RAM read; a remove moves each later entry down one place through
// the single RAM write port; a dump reads the entries in order. The RAM is
// not cleared after reset, so the block accepts beats from the first cycle.

module indexed_sequence_store_core
    import isq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [MODE_W-1:0]        mode,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic signed [DATA_W-1:0] item_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      data,
    output logic                          ok,
    output logic                          last
);

    logic q_valid;
    op_t  q_op;
    logic q_pop;

    isq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .position   (position),
        .item_value (item_value),
        .q_valid    (q_valid),
        .q_op       (q_op),
        .q_pop      (q_pop)
    );

    isq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .ok        (ok),
        .last      (last)
    );

endmodule

`default_nettype wire
